### design/sofbt_pkg.sv
package sofbt_pkg;

    // Operation codes carried by a request
    typedef enum logic [2:0] {
        OP_ADD          = 3'd0,
        OP_REMOVE_ADDR  = 3'd1,
        OP_REMOVE_INDEX = 3'd2,
        OP_BEST_FIT     = 3'd3,
        OP_FIND_ADDR    = 3'd4
    } opcode_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NO_ADDR   = 3'd2,
        STAT_BAD_INDEX = 3'd3,
        STAT_NO_FIT    = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RM_FETCH,
        S_RM_SHIFT,
        S_ADD_WALK,
        S_ADD_PUT,
        S_FINISH
    } state_t;

    // Read address select for the entry memory
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_INDEX,
        RD_LAST,
        RD_NEXT,
        RD_PREV
    } rd_sel_t;

    // Write select for the entry memory
    typedef enum logic [2:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN,
        WR_NEW_NEXT,
        WR_NEW_ZERO
    } wr_sel_t;

    // Result register update select
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ERR,
        RES_DATA,
        RES_NEW_NEXT,
        RES_NEW_ZERO,
        RES_CLEAR
    } res_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     rd_en;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        res_sel_t res_sel;
        status_t  res_status;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic [2:0] op;
        logic       count_zero;
        logic       full;
        logic       idx_bad;
        logic       rd_first;
        logic       rd_last;
        logic       addr_match;
        logic       size_lt;
        logic       size_eq;
        logic       out_free;
    } stat_t;

endpackage

### design/sofbt_if.sv
interface sofbt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] block_size;
    logic [31:0] block_address;
    logic [7:0]  entry_index;

    modport source (output valid, output opcode, output block_size, output block_address,
                    output entry_index, input ready);
    modport sink (input valid, input opcode, input block_size, input block_address,
                  input entry_index, output ready);
endinterface

interface sofbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  found_index;
    logic [31:0] found_size;
    logic [31:0] found_address;
    logic [8:0]  entry_count;

    modport source (output valid, output status, output found_index, output found_size,
                    output found_address, output entry_count, input ready);
    modport sink (input valid, input status, input found_index, input found_size,
                  input found_address, input entry_count, output ready);
endinterface

interface sofbt_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] table_limit;

    modport source (output valid, output table_limit, input ready);
    modport sink (input valid, input table_limit, output ready);
endinterface

### design/sofbt_ctrl.sv
module sofbt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  sofbt_pkg::stat_t stat,
    output sofbt_pkg::cmd_t  cmd
);

    sofbt_pkg::state_t state_reg;
    sofbt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sofbt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = sofbt_pkg::RD_ZERO;
        cmd.wr_sel     = sofbt_pkg::WR_NONE;
        cmd.res_sel    = sofbt_pkg::RES_HOLD;
        cmd.res_status = sofbt_pkg::STAT_OK;

        case (state_reg)
            sofbt_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = sofbt_pkg::S_DECODE;
                end
            end

            // Check the error cases, write an add into an empty table directly, and otherwise issue the first read
            sofbt_pkg::S_DECODE:
            begin
                state_next = sofbt_pkg::S_FINISH;
                case (stat.op)
                    sofbt_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_sel    = sofbt_pkg::RES_ERR;
                            cmd.res_status = sofbt_pkg::STAT_FULL;
                        end
                        else if (stat.count_zero)
                        begin
                            cmd.wr_sel  = sofbt_pkg::WR_NEW_ZERO;
                            cmd.res_sel = sofbt_pkg::RES_NEW_ZERO;
                            cmd.cnt_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sofbt_pkg::RD_LAST;
                            state_next = sofbt_pkg::S_ADD_WALK;
                        end
                    end
                    sofbt_pkg::OP_REMOVE_ADDR, sofbt_pkg::OP_FIND_ADDR:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.res_sel    = sofbt_pkg::RES_ERR;
                            cmd.res_status = sofbt_pkg::STAT_NO_ADDR;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sofbt_pkg::RD_ZERO;
                            state_next = sofbt_pkg::S_SCAN;
                        end
                    end
                    sofbt_pkg::OP_REMOVE_INDEX:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.res_sel    = sofbt_pkg::RES_ERR;
                            cmd.res_status = sofbt_pkg::STAT_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sofbt_pkg::RD_INDEX;
                            state_next = sofbt_pkg::S_RM_FETCH;
                        end
                    end
                    sofbt_pkg::OP_BEST_FIT:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.res_sel    = sofbt_pkg::RES_ERR;
                            cmd.res_status = sofbt_pkg::STAT_NO_FIT;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sofbt_pkg::RD_ZERO;
                            state_next = sofbt_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_sel = sofbt_pkg::RES_CLEAR;
                    end
                endcase
            end

            // Walk from the head, one entry per cycle
            sofbt_pkg::S_SCAN:
            begin
                case (stat.op)
                    sofbt_pkg::OP_BEST_FIT:
                    begin
                        if (stat.size_lt)
                        begin
                            if (stat.rd_first)
                            begin
                                cmd.res_sel    = sofbt_pkg::RES_ERR;
                                cmd.res_status = sofbt_pkg::STAT_NO_FIT;
                            end
                            state_next = sofbt_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.res_sel = sofbt_pkg::RES_DATA;
                            if (stat.size_eq || stat.rd_last)
                            begin
                                state_next = sofbt_pkg::S_FINISH;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sofbt_pkg::RD_NEXT;
                            end
                        end
                    end
                    sofbt_pkg::OP_REMOVE_ADDR, sofbt_pkg::OP_FIND_ADDR:
                    begin
                        if (stat.addr_match)
                        begin
                            cmd.res_sel = sofbt_pkg::RES_DATA;
                            if (stat.op == sofbt_pkg::OP_FIND_ADDR)
                            begin
                                state_next = sofbt_pkg::S_FINISH;
                            end
                            else if (stat.rd_last)
                            begin
                                cmd.cnt_dec = 1'b1;
                                state_next  = sofbt_pkg::S_FINISH;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sofbt_pkg::RD_NEXT;
                                state_next = sofbt_pkg::S_RM_SHIFT;
                            end
                        end
                        else if (stat.rd_last)
                        begin
                            cmd.res_sel    = sofbt_pkg::RES_ERR;
                            cmd.res_status = sofbt_pkg::STAT_NO_ADDR;
                            state_next     = sofbt_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sofbt_pkg::RD_NEXT;
                        end
                    end
                    default:
                    begin
                        state_next = sofbt_pkg::S_FINISH;
                    end
                endcase
            end

            // Capture the entry picked by index
            sofbt_pkg::S_RM_FETCH:
            begin
                cmd.res_sel = sofbt_pkg::RES_DATA;
                if (stat.rd_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = sofbt_pkg::S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sofbt_pkg::RD_NEXT;
                    state_next = sofbt_pkg::S_RM_SHIFT;
                end
            end

            // Close the gap: move each later entry down by one
            sofbt_pkg::S_RM_SHIFT:
            begin
                cmd.wr_sel = sofbt_pkg::WR_SHIFT_DOWN;
                if (stat.rd_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = sofbt_pkg::S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sofbt_pkg::RD_NEXT;
                end
            end

            // Walk from the tail, moving smaller entries up until the slot is found
            sofbt_pkg::S_ADD_WALK:
            begin
                if (stat.size_lt)
                begin
                    cmd.wr_sel = sofbt_pkg::WR_SHIFT_UP;
                    if (stat.rd_first)
                    begin
                        state_next = sofbt_pkg::S_ADD_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sofbt_pkg::RD_PREV;
                    end
                end
                else
                begin
                    cmd.wr_sel  = sofbt_pkg::WR_NEW_NEXT;
                    cmd.res_sel = sofbt_pkg::RES_NEW_NEXT;
                    cmd.cnt_inc = 1'b1;
                    state_next  = sofbt_pkg::S_FINISH;
                end
            end

            // New entry goes to the head
            sofbt_pkg::S_ADD_PUT:
            begin
                cmd.wr_sel  = sofbt_pkg::WR_NEW_ZERO;
                cmd.res_sel = sofbt_pkg::RES_NEW_ZERO;
                cmd.cnt_inc = 1'b1;
                state_next  = sofbt_pkg::S_FINISH;
            end

            // Hand the result to the output register once it is free
            sofbt_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sofbt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sofbt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/sofbt_dpath.sv
module sofbt_dpath #(
    parameter int CAPACITY = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    sofbt_req_if.sink        req,
    sofbt_rsp_if.source      rsp,
    sofbt_cfg_if.sink        cfg,
    input  sofbt_pkg::cmd_t  cmd,
    output sofbt_pkg::stat_t stat
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // Latched request
    logic [2:0]  op_reg;
    logic [31:0] key_size_reg;
    logic [31:0] key_addr_reg;
    logic [7:0]  key_idx_reg;

    // Control state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [8:0]       limit_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Entry memory: {size, address}
    logic [63:0]      entry_mem [CAPACITY];
    logic [63:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_dec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      wr_data;
    logic [31:0]      rd_size;
    logic [31:0]      rd_address;

    // Result and output registers
    logic [2:0]  res_status_reg;
    logic [7:0]  res_idx_reg;
    logic [31:0] res_size_reg;
    logic [31:0] res_addr_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_idx_reg;
    logic [31:0] out_size_reg;
    logic [31:0] out_addr_reg;
    logic [8:0]  out_count_reg;

    logic load_op;

    assign load_op    = req.valid & cmd.in_ready;
    assign req.ready  = cmd.in_ready;
    assign cfg.ready  = 1'b1;
    assign rd_size    = rd_data_reg[63:32];
    assign rd_address = rd_data_reg[31:0];
    assign idx_inc    = rd_idx_reg + IDX_W'(1);
    assign idx_dec    = rd_idx_reg - IDX_W'(1);

    // Status toward the controller
    always_comb
    begin
        stat            = '0;
        stat.in_valid   = req.valid;
        stat.op         = op_reg;
        stat.count_zero = (count_reg == '0);
        stat.full       = (CMP_W'(count_reg) >= CMP_W'(limit_reg)) ||
                          (count_reg == CNT_W'(CAPACITY));
        stat.idx_bad    = (CMP_W'(key_idx_reg) >= CMP_W'(count_reg));
        stat.rd_first   = (rd_idx_reg == '0);
        stat.rd_last    = (CNT_W'(rd_idx_reg) == (count_reg - CNT_W'(1)));
        stat.addr_match = (rd_address == key_addr_reg);
        stat.size_lt    = (rd_size < key_size_reg);
        stat.size_eq    = (rd_size == key_size_reg);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            sofbt_pkg::RD_ZERO:  rd_addr = '0;
            sofbt_pkg::RD_INDEX: rd_addr = IDX_W'(key_idx_reg);
            sofbt_pkg::RD_LAST:  rd_addr = IDX_W'(count_reg - CNT_W'(1));
            sofbt_pkg::RD_NEXT:  rd_addr = idx_inc;
            sofbt_pkg::RD_PREV:  rd_addr = idx_dec;
            default:             rd_addr = '0;
        endcase
    end

    // Write address and data select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = rd_data_reg;
        case (cmd.wr_sel)
            sofbt_pkg::WR_SHIFT_UP:
            begin
                wr_addr = idx_inc;
            end
            sofbt_pkg::WR_SHIFT_DOWN:
            begin
                wr_addr = idx_dec;
            end
            sofbt_pkg::WR_NEW_NEXT:
            begin
                wr_addr = idx_inc;
                wr_data = {key_size_reg, key_addr_reg};
            end
            sofbt_pkg::WR_NEW_ZERO:
            begin
                wr_data = {key_size_reg, key_addr_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Count and output valid next values
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= 9'd256;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.table_limit;
            end
        end
    end

    // Request latch, result and output payload
    always_ff @(posedge clk)
    begin
        if (load_op)
        begin
            op_reg       <= req.opcode;
            key_size_reg <= req.block_size;
            key_addr_reg <= req.block_address;
            key_idx_reg  <= req.entry_index;
        end

        case (cmd.res_sel)
            sofbt_pkg::RES_ERR:
            begin
                res_status_reg <= cmd.res_status;
                res_idx_reg    <= '0;
                res_size_reg   <= '0;
                res_addr_reg   <= '0;
            end
            sofbt_pkg::RES_DATA:
            begin
                res_status_reg <= sofbt_pkg::STAT_OK;
                res_idx_reg    <= 8'(rd_idx_reg);
                res_size_reg   <= rd_size;
                res_addr_reg   <= rd_address;
            end
            sofbt_pkg::RES_NEW_NEXT:
            begin
                res_status_reg <= sofbt_pkg::STAT_OK;
                res_idx_reg    <= 8'(idx_inc);
                res_size_reg   <= key_size_reg;
                res_addr_reg   <= key_addr_reg;
            end
            sofbt_pkg::RES_NEW_ZERO:
            begin
                res_status_reg <= sofbt_pkg::STAT_OK;
                res_idx_reg    <= '0;
                res_size_reg   <= key_size_reg;
                res_addr_reg   <= key_addr_reg;
            end
            sofbt_pkg::RES_CLEAR:
            begin
                res_status_reg <= sofbt_pkg::STAT_OK;
                res_idx_reg    <= '0;
                res_size_reg   <= '0;
                res_addr_reg   <= '0;
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_size_reg   <= res_size_reg;
            out_addr_reg   <= res_addr_reg;
            out_count_reg  <= 9'(count_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_index   = out_idx_reg;
    assign rsp.found_size    = out_size_reg;
    assign rsp.found_address = out_addr_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule

### design/size_ordered_free_block_table_top.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   opcode, block_size, block_address, entry_index
// rsp      out  valid/ready   status, found_index, found_size, found_address, entry_count
// cfg      in   valid/ready   table_limit (always ready)
//
// One request at a time. Add walks from the tail to its slot, removes walk
// from the hit to the tail, searches walk from the head; the single read and
// single write per cycle of the entry memory set the pace of each walk.
// Reset clears the entry count and sets the limit to 256; entries are
// undefined until written, no clearing pass. A stalled result holds in the
// output register; the next request is taken while it waits.
module size_ordered_free_block_table_top #(
    parameter int CAPACITY = 256
) (
    input logic         clk,
    input logic         rst_n,
    sofbt_req_if.sink   req,
    sofbt_rsp_if.source rsp,
    sofbt_cfg_if.sink   cfg
);

    sofbt_pkg::cmd_t  cmd;
    sofbt_pkg::stat_t stat;

    sofbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    sofbt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Result loads only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over a pending result");

    // One request in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while busy");

    // Error results carry zero found fields
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != sofbt_pkg::STAT_OK) |->
            (rsp.found_index == '0) && (rsp.found_size == '0) &&
            (rsp.found_address == '0))
        else $error("error result with nonzero found fields");

    // Memory write and count change never happen while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.in_ready |-> (cmd.wr_sel == sofbt_pkg::WR_NONE) && !cmd.cnt_inc && !cmd.cnt_dec)
        else $error("table modified while idle");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int TABLE_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE = 48;
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] size;
        logic [31:0] addr;
        logic [7:0]  idx;
    } table_op_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  index;
        logic [31:0] size;
        logic [31:0] addr;
        logic [8:0]  count;
    } table_reply_t;

    logic clk;
    logic rst_n;

    sofbt_req_if req();
    sofbt_rsp_if rsp();
    sofbt_cfg_if cfg();

    size_ordered_free_block_table_top #(.CAPACITY(TABLE_DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow copy of the block's table and limit register
    logic [31:0] held_size [TABLE_DEPTH];
    logic [31:0] held_addr [TABLE_DEPTH];
    int          held_count;
    logic [8:0]  limit_copy;

    table_op_t    ops_to_send [$];
    table_reply_t predicted_replies [$];
    logic [31:0]  addr_pool [POOL_SIZE];

    int  issued;
    int  accepted_cnt;
    int  fail_count;
    int  quiet_cycles;
    int  send_gap;
    int  send_calm;
    int  stall_left;
    int  stall_calm;
    int  limit_writes;
    int  peak_count;
    int  op_seen [8];
    int  status_seen [8];
    logic req_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shift later entries down over the removed position
    function automatic void close_gap(int pos);
        int i;
        for (i = pos; i + 1 < held_count; i++)
        begin
            held_size[i] = held_size[i + 1];
            held_addr[i] = held_addr[i + 1];
        end
        held_count--;
    endfunction

    // Apply one request to the shadow table and return the reply it earns
    function automatic table_reply_t apply_table_op(table_op_t op);
        table_reply_t r;
        int lim;
        int pos;
        int i;
        r = '0;
        r.status = sofbt_pkg::STAT_OK;
        lim = (limit_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(limit_copy);
        case (op.opcode)
            sofbt_pkg::OP_ADD:
            begin
                if (held_count >= lim)
                    r.status = sofbt_pkg::STAT_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_count && held_size[pos] >= op.size)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_size[i] = held_size[i - 1];
                        held_addr[i] = held_addr[i - 1];
                    end
                    held_size[pos] = op.size;
                    held_addr[pos] = op.addr;
                    held_count++;
                    r.index = pos[7:0];
                    r.size = op.size;
                    r.addr = op.addr;
                end
            end
            sofbt_pkg::OP_REMOVE_ADDR, sofbt_pkg::OP_FIND_ADDR:
            begin
                pos = -1;
                for (i = 0; i < held_count; i++)
                begin
                    if (pos < 0 && held_addr[i] == op.addr)
                        pos = i;
                end
                if (pos < 0)
                    r.status = sofbt_pkg::STAT_NO_ADDR;
                else
                begin
                    r.index = pos[7:0];
                    r.size = held_size[pos];
                    r.addr = held_addr[pos];
                    if (op.opcode == sofbt_pkg::OP_REMOVE_ADDR)
                        close_gap(pos);
                end
            end
            sofbt_pkg::OP_REMOVE_INDEX:
            begin
                if (int'(op.idx) >= held_count)
                    r.status = sofbt_pkg::STAT_BAD_INDEX;
                else
                begin
                    r.index = op.idx;
                    r.size = held_size[op.idx];
                    r.addr = held_addr[op.idx];
                    close_gap(int'(op.idx));
                end
            end
            sofbt_pkg::OP_BEST_FIT:
            begin
                if (held_count == 0 || held_size[0] < op.size)
                    r.status = sofbt_pkg::STAT_NO_FIT;
                else
                begin
                    pos = 0;
                    for (i = 0; i < held_count; i++)
                    begin
                        if (held_size[i] < op.size)
                            break;
                        pos = i;
                        if (held_size[i] == op.size)
                            break;
                    end
                    r.index = pos[7:0];
                    r.size = held_size[pos];
                    r.addr = held_addr[pos];
                end
            end
            default:
            begin
            end
        endcase
        r.count = held_count[8:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 32'h0000_0000;
        if (roll < 10)
            return 32'hFFFF_FFFF;
        if (roll < 45)
            return 32'($urandom_range(1, 12) * 64);
        return $urandom;
    endfunction

    // Build a request that mostly hits live entries of the table
    function automatic table_op_t make_random_op(int add_pct);
        table_op_t op;
        int roll;
        int pick;
        op.size = pick_size();
        op.addr = ($urandom_range(0, 2) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
        op.idx = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            op.opcode = sofbt_pkg::OP_ADD;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 24)
                op.opcode = sofbt_pkg::OP_REMOVE_ADDR;
            else if (roll < 48)
                op.opcode = sofbt_pkg::OP_REMOVE_INDEX;
            else if (roll < 72)
                op.opcode = sofbt_pkg::OP_BEST_FIT;
            else if (roll < 94)
                op.opcode = sofbt_pkg::OP_FIND_ADDR;
            else
                op.opcode = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        end
        if (held_count > 0)
        begin
            pick = $urandom_range(0, held_count - 1);
            if ($urandom_range(0, 3) != 0)
                op.idx = pick[7:0];
            if (op.opcode != sofbt_pkg::OP_ADD ? $urandom_range(0, 3) != 0
                                               : $urandom_range(0, 7) == 0)
                op.addr = held_addr[$urandom_range(0, held_count - 1)];
            if (op.opcode == sofbt_pkg::OP_BEST_FIT)
            begin
                roll = $urandom_range(0, 3);
                if (roll < 2)
                    op.size = held_size[pick];
                else if (roll == 2)
                    op.size = held_size[pick] + 32'd1;
            end
        end
        return op;
    endfunction

    task automatic queue_op(input logic [2:0] code, input logic [31:0] sz,
                            input logic [31:0] addr, input logic [7:0] ix);
        table_op_t op;
        op.opcode = code;
        op.size = sz;
        op.addr = addr;
        op.idx = ix;
        issued++;
        ops_to_send.push_back(op);
    endtask

    task automatic run_random(input int count, input int add_pct);
        table_op_t op;
        repeat (count)
        begin
            while (ops_to_send.size() >= 2)
                @(negedge clk);
            op = make_random_op(add_pct);
            queue_op(op.opcode, op.size, op.addr, op.idx);
        end
    endtask

    task automatic wait_for_idle();
        while (issued != accepted_cnt || predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    // Write the limit register once the table has gone quiet
    task automatic write_limit(input logic [8:0] value);
        wait_for_idle();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.table_limit <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        limit_writes++;
    endtask

    // Request driver: present queued requests with random gaps between them
    always @(negedge clk)
    begin
        table_op_t nxt;
        if (rst_n && (!req.valid || req_taken))
        begin
            if (send_gap > 0)
            begin
                req.valid <= 1'b0;
                send_gap--;
            end
            else if (ops_to_send.size() > 0)
            begin
                nxt = ops_to_send.pop_front();
                req.valid <= 1'b1;
                req.opcode <= nxt.opcode;
                req.block_size <= nxt.size;
                req.block_address <= nxt.addr;
                req.entry_index <= nxt.idx;
                send_gap = pick_gap(send_calm);
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Reply sink: stall ready at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    stall_left = pick_gap(stall_calm);
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted reply
    always @(posedge clk)
    begin
        table_op_t    got_op;
        table_reply_t want;
        if (rst_n)
        begin
            req_taken <= req.valid && req.ready;
            if (req.valid && req.ready)
            begin
                got_op.opcode = req.opcode;
                got_op.size = req.block_size;
                got_op.addr = req.block_address;
                got_op.idx = req.entry_index;
                predicted_replies.push_back(apply_table_op(got_op));
                op_seen[req.opcode]++;
                accepted_cnt++;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("reply with no request outstanding: status %0d", rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    status_seen[rsp.status]++;
                    if (rsp.entry_count > peak_count)
                        peak_count = rsp.entry_count;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.found_index !== want.index)
                    begin
                        $error("found_index: expected %0d, got %0d", want.index,
                               rsp.found_index);
                        fail_count++;
                    end
                    if (rsp.found_size !== want.size)
                    begin
                        $error("found_size: expected %08h, got %08h", want.size,
                               rsp.found_size);
                        fail_count++;
                    end
                    if (rsp.found_address !== want.addr)
                    begin
                        $error("found_address: expected %08h, got %08h", want.addr,
                               rsp.found_address);
                        fail_count++;
                    end
                    if (rsp.entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               rsp.entry_count);
                        fail_count++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                limit_copy = cfg.table_limit;
            // Abort if nothing moves for too long
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        int guard;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = sofbt_pkg::OP_ADD;
        req.block_size = '0;
        req.block_address = '0;
        req.entry_index = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.table_limit = '0;
        req_taken = 1'b0;
        held_count = 0;
        limit_copy = 9'd256;
        issued = 0;
        accepted_cnt = 0;
        fail_count = 0;
        quiet_cycles = 0;
        send_gap = 0;
        send_calm = 0;
        stall_left = 0;
        stall_calm = 0;
        limit_writes = 0;
        peak_count = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        addr_a = 32'h0000_1000;
        addr_b = 32'h8000_0040;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, extreme sizes, full at a small limit, unknown opcodes
        write_limit(9'd2);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'h0000_0000, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_INDEX, 32'h0, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_ADDR, 32'h0, addr_a, 8'd0);
        queue_op(sofbt_pkg::OP_FIND_ADDR, 32'h0, 32'hFFFF_FFFF, 8'd0);
        queue_op(OP_RESERVED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        queue_op(sofbt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        queue_op(sofbt_pkg::OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 8'd255);
        queue_op(sofbt_pkg::OP_ADD, 32'h0000_0040, addr_b, 8'd0);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'h0000_0000, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'hFFFF_FFFF, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'h0000_0001, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_FIND_ADDR, 32'h0, 32'hFFFF_FFFF, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_INDEX, 32'h0, 32'h0, 8'd255);
        queue_op(OP_RESERVED_FIRST, 32'h0, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_ADDR, 32'h0, 32'h0000_0000, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_INDEX, 32'h0, 32'h0, 8'd0);

        // Zero limit refuses every add
        write_limit(9'd0);
        queue_op(sofbt_pkg::OP_ADD, 32'h0000_0010, addr_a, 8'd0);

        // Duplicate addresses, equal sizes, nothing large enough
        write_limit(9'd511);
        queue_op(sofbt_pkg::OP_ADD, 32'd10, addr_a, 8'd0);
        queue_op(sofbt_pkg::OP_ADD, 32'd10, addr_a, 8'd0);
        queue_op(sofbt_pkg::OP_ADD, 32'd20, addr_b, 8'd0);
        queue_op(sofbt_pkg::OP_FIND_ADDR, 32'h0, addr_a, 8'd0);
        queue_op(sofbt_pkg::OP_REMOVE_ADDR, 32'h0, addr_a, 8'd0);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'd15, 32'h0, 8'd0);
        queue_op(sofbt_pkg::OP_BEST_FIT, 32'd25, 32'h0, 8'd0);

        // Fill to capacity, then push against the full table
        write_limit(9'd256);
        guard = 0;
        while (held_count < TABLE_DEPTH && guard < 1200)
        begin
            run_random(1, 90);
            guard++;
        end
        run_random(40, 60);

        // Walk the limit through small, zero, saturated and mid settings
        write_limit(9'd1);
        run_random(150, 40);
        write_limit(9'd0);
        run_random(60, 40);
        write_limit(9'd16);
        run_random(300, 45);
        write_limit(9'd300);
        run_random(300, 50);
        write_limit(9'd64);
        run_random(350, 45);
        write_limit(9'd511);
        run_random(400, 50);

        wait_for_idle();
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests over %0d limit settings: add %0d, remove-addr %0d, %s %0d,",
                 accepted_cnt, limit_writes, op_seen[sofbt_pkg::OP_ADD],
                 op_seen[sofbt_pkg::OP_REMOVE_ADDR], "remove-index",
                 op_seen[sofbt_pkg::OP_REMOVE_INDEX]);
        $display("best-fit %0d, find %0d; %s %0d/%0d/%0d/%0d/%0d, peak %0d entries",
                 op_seen[sofbt_pkg::OP_BEST_FIT], op_seen[sofbt_pkg::OP_FIND_ADDR],
                 "statuses ok/full/no-addr/bad-index/no-fit",
                 status_seen[sofbt_pkg::STAT_OK], status_seen[sofbt_pkg::STAT_FULL],
                 status_seen[sofbt_pkg::STAT_NO_ADDR], status_seen[sofbt_pkg::STAT_BAD_INDEX],
                 status_seen[sofbt_pkg::STAT_NO_FIT], peak_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
